### hdl/ndim_pkg.sv
// ============================================================================
// ndim_pkg
// Shared widths, command and status codes, and controller/datapath
// interface structs for the node DOF index map.
// ============================================================================
`default_nettype none

package ndim_pkg;

    localparam int CMD_W  = 2;
    localparam int NODE_W = 10;
    localparam int DOF_W  = 3;
    localparam int ST_W   = 3;
    localparam int IDX_W  = 13;
    localparam int NC_W   = 11;
    localparam int PC_W   = 4;

    localparam int DEF_MAX_NODES = 1024;
    localparam int DEF_DOF_KINDS = 6;

    localparam logic [NC_W-1:0]  NC_RESET = 11'd1024;
    localparam logic [IDX_W-1:0] IDX_MAX  = 13'd8191;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_UNKNOWN = 3'd1;
    localparam logic [ST_W-1:0] ST_ABSENT  = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE   = 3'd4;

    localparam logic [2:0] REG_NODE_COUNT = 3'd0;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic build_start;
        logic build_step;
        logic exec_load;
        logic build_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic walk_done;
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/ndim_ram.sv
// ============================================================================
// ndim_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module ndim_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/ndim_ctrl.sv
// ============================================================================
// ndim_ctrl
// Controller: clearing pass after reset, request accept, execute step,
// offset build walk and result handshake.
// ============================================================================
`default_nettype none

module ndim_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    input  wire logic                  req_is_build,
    input  wire logic                  rsp_ready,
    input  wire ndim_pkg::dp_status_t  dp_status,
    output logic                       req_ready,
    output logic                       rsp_valid,
    output ndim_pkg::ctrl_cmd_t        ctrl_cmd
);

    import ndim_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_BUILD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       accept;

    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        ctrl_cmd   = '0;
        case (state_reg)
            S_CLEAR:
            begin
                ctrl_cmd.clear_step = 1'b1;
                if (dp_status.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl_cmd.accept = 1'b1;
                    if (req_is_build)
                    begin
                        ctrl_cmd.build_start = 1'b1;
                        state_next = S_BUILD;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                ctrl_cmd.exec_load = 1'b1;
                state_next = S_IDLE;
            end
            S_BUILD:
            begin
                if (dp_status.walk_done)
                begin
                    ctrl_cmd.build_load = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctrl_cmd.build_step = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (ctrl_cmd.exec_load || ctrl_cmd.build_load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/ndim_dp.sv
// ============================================================================
// ndim_dp
// Datapath: mask and offset memories, clear and walk counters, running
// sum, request registers and result registers.
// ============================================================================
`default_nettype none

module ndim_dp #(
    parameter int MAX_NODES = ndim_pkg::DEF_MAX_NODES,
    parameter int DOF_KINDS = ndim_pkg::DEF_DOF_KINDS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ndim_pkg::ctrl_cmd_t          ctrl_cmd,
    input  wire logic [ndim_pkg::CMD_W-1:0]   cmd,
    input  wire logic [ndim_pkg::NODE_W-1:0]  node,
    input  wire logic [ndim_pkg::DOF_W-1:0]   dof_code,
    input  wire logic [ndim_pkg::NC_W-1:0]    node_count,
    output ndim_pkg::dp_status_t              dp_status,
    output logic      [ndim_pkg::ST_W-1:0]    status,
    output logic      [ndim_pkg::IDX_W-1:0]   dof_index
);

    import ndim_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    function automatic logic [AW-1:0] to_addr(input logic [31:0] v);
        return v[AW-1:0];
    endfunction

    function automatic logic [PC_W-1:0] pop_count(input logic [DOF_KINDS-1:0] v);
        logic [PC_W-1:0] n;
        n = '0;
        for (int k = 0; k < DOF_KINDS; k++)
        begin
            n = n + PC_W'(v[k]);
        end
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] sat_add(input logic [IDX_W-1:0] a,
                                                 input logic [PC_W-1:0]  b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + (IDX_W + 1)'(b);
        return s[IDX_W] ? IDX_MAX : s[IDX_W-1:0];
    endfunction

    logic [AW-1:0]        clr_cnt_reg;
    logic [NC_W-1:0]      issue_cnt_reg;
    logic [NC_W-1:0]      count_reg;
    logic [NC_W-1:0]      built_count_reg;
    logic                 pvalid_reg;
    logic [AW-1:0]        paddr_reg;
    logic [IDX_W-1:0]     sum_reg;
    logic                 empty_reg;
    logic [CMD_W-1:0]     cmd_reg;
    logic [NODE_W-1:0]    node_reg;
    logic [DOF_W-1:0]     dof_reg;
    logic [ST_W-1:0]      status_reg;
    logic [IDX_W-1:0]     index_reg;

    logic [NC_W-1:0]      count_eff;
    logic                 issue_now;
    logic [PC_W-1:0]      walk_size;

    logic                 mask_we;
    logic [AW-1:0]        mask_waddr;
    logic [DOF_KINDS-1:0] mask_wdata;
    logic [AW-1:0]        mask_raddr;
    logic [DOF_KINDS-1:0] mask_rdata;
    logic [IDX_W-1:0]     offset_rdata;

    logic [DOF_KINDS-1:0] dof_onehot;
    logic [DOF_KINDS-1:0] dof_below;
    logic                 dof_unknown;
    logic                 node_over;
    logic                 query_over;
    logic [ST_W-1:0]      exec_status;
    logic [IDX_W-1:0]     exec_index;
    logic                 exec_write;

    assign count_eff = (32'(node_count) > 32'(MAX_NODES)) ? NC_W'(MAX_NODES) : node_count;
    assign issue_now = ctrl_cmd.build_step && (issue_cnt_reg < count_reg);
    assign walk_size = pop_count(mask_rdata);

    assign dp_status.clear_done = (32'(clr_cnt_reg) == 32'(MAX_NODES - 1));
    assign dp_status.walk_done  = (issue_cnt_reg == count_reg) && !pvalid_reg;

    always_comb
    begin
        for (int k = 0; k < DOF_KINDS; k++)
        begin
            dof_onehot[k] = (32'(dof_reg) == k);
            dof_below[k]  = (32'(dof_reg) > k);
        end
    end

    assign dof_unknown = 32'(dof_reg) >= 32'(DOF_KINDS);
    assign node_over   = 32'(node_reg) >= 32'(MAX_NODES);
    assign query_over  = (32'(node_reg) >= 32'(built_count_reg)) || node_over;

    always_comb
    begin
        exec_status = ST_OK;
        exec_index  = '0;
        exec_write  = 1'b0;
        if (dof_unknown)
        begin
            exec_status = ST_UNKNOWN;
        end
        else if (cmd_reg == CMD_QUERY)
        begin
            if (query_over)
            begin
                exec_status = ST_RANGE;
            end
            else if ((mask_rdata & dof_onehot) == '0)
            begin
                exec_status = ST_ABSENT;
            end
            else
            begin
                exec_index = sat_add(offset_rdata, pop_count(mask_rdata & dof_below));
            end
        end
        else if (node_over)
        begin
            exec_status = ST_RANGE;
        end
        else
        begin
            exec_write = 1'b1;
        end
    end

    always_comb
    begin
        mask_we    = 1'b0;
        mask_waddr = to_addr(32'(node_reg));
        mask_wdata = (cmd_reg == CMD_ADD) ? (mask_rdata | dof_onehot)
                                          : (mask_rdata & ~dof_onehot);
        if (ctrl_cmd.clear_step)
        begin
            mask_we    = 1'b1;
            mask_waddr = clr_cnt_reg;
            mask_wdata = '0;
        end
        else if (ctrl_cmd.exec_load && exec_write)
        begin
            mask_we = 1'b1;
        end
    end

    assign mask_raddr = ctrl_cmd.build_step ? to_addr(32'(issue_cnt_reg)) : to_addr(32'(node));

    ndim_ram #(
        .WIDTH (DOF_KINDS),
        .DEPTH (MAX_NODES)
    ) u_mask_ram (
        .clk   (clk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    ndim_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_NODES)
    ) u_offset_ram (
        .clk   (clk),
        .we    (ctrl_cmd.build_step && pvalid_reg),
        .waddr (paddr_reg),
        .wdata (sum_reg),
        .raddr (to_addr(32'(node))),
        .rdata (offset_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg     <= '0;
            issue_cnt_reg   <= '0;
            count_reg       <= '0;
            built_count_reg <= '0;
            pvalid_reg      <= 1'b0;
            sum_reg         <= '0;
            empty_reg       <= 1'b0;
        end
        else
        begin
            if (ctrl_cmd.clear_step && !dp_status.clear_done)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (ctrl_cmd.build_start)
            begin
                issue_cnt_reg <= '0;
                count_reg     <= count_eff;
                pvalid_reg    <= 1'b0;
                sum_reg       <= '0;
                empty_reg     <= 1'b0;
            end
            else if (ctrl_cmd.build_step)
            begin
                pvalid_reg <= issue_now;
                if (issue_now)
                begin
                    issue_cnt_reg <= issue_cnt_reg + NC_W'(1);
                end
                if (pvalid_reg)
                begin
                    sum_reg <= sat_add(sum_reg, walk_size);
                    if (walk_size == '0)
                    begin
                        empty_reg <= 1'b1;
                    end
                end
            end
            if (ctrl_cmd.build_load)
            begin
                built_count_reg <= count_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue_now)
        begin
            paddr_reg <= to_addr(32'(issue_cnt_reg));
        end
        if (ctrl_cmd.accept)
        begin
            cmd_reg  <= cmd;
            node_reg <= node;
            dof_reg  <= dof_code;
        end
        if (ctrl_cmd.exec_load)
        begin
            status_reg <= exec_status;
            index_reg  <= exec_index;
        end
        else if (ctrl_cmd.build_load)
        begin
            status_reg <= empty_reg ? ST_EMPTY : ST_OK;
            index_reg  <= sum_reg;
        end
    end

    assign status    = status_reg;
    assign dof_index = index_reg;

endmodule

`default_nettype wire

### hdl/node_dof_index_map.sv
// ============================================================================
// node_dof_index_map
// Per-node DOF mask store with offset build and global DOF index query.
//
//  channel   signals                               direction
//  -------   -----------------------------------   ---------
//  request   req_valid req_ready cmd node dof_code  in (req_ready out)
//  response  rsp_valid rsp_ready status dof_index   out (rsp_ready in)
//  config    psel penable pwrite paddr pwdata       in (APB)
//            prdata pready                          out
//
// Add, remove and query do one mask/offset memory read, then the result
// and mask write-back. Build walks count = min(node_count, MAX_NODES)
// nodes, one node per cycle through the mask memory read port. After
// reset a clearing pass zeroes the mask memory; no request is taken
// meanwhile. A stalled response holds the next request until it is
// taken or taken in the same cycle.
// ============================================================================
`default_nettype none

module node_dof_index_map #(
    parameter int MAX_NODES = ndim_pkg::DEF_MAX_NODES,
    parameter int DOF_KINDS = ndim_pkg::DEF_DOF_KINDS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         req_valid,
    output logic                              req_ready,
    input  wire logic [ndim_pkg::CMD_W-1:0]   cmd,
    input  wire logic [ndim_pkg::NODE_W-1:0]  node,
    input  wire logic [ndim_pkg::DOF_W-1:0]   dof_code,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output logic      [ndim_pkg::ST_W-1:0]    status,
    output logic      [ndim_pkg::IDX_W-1:0]   dof_index,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [2:0]                   paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready
);

    import ndim_pkg::*;

    logic [NC_W-1:0] node_count_reg;
    ctrl_cmd_t       ctrl_cmd;
    dp_status_t      dp_status;
    logic            cfg_write;
    logic            reg_hit;

    assign pready    = 1'b1;
    assign reg_hit   = ({paddr[2], 2'b00} == REG_NODE_COUNT);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata    = reg_hit ? 32'(node_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NC_RESET;
        end
        else if (cfg_write)
        begin
            node_count_reg <= pwdata[NC_W-1:0];
        end
    end

    ndim_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_is_build (cmd == CMD_BUILD),
        .rsp_ready    (rsp_ready),
        .dp_status    (dp_status),
        .req_ready    (req_ready),
        .rsp_valid    (rsp_valid),
        .ctrl_cmd     (ctrl_cmd)
    );

    ndim_dp #(
        .MAX_NODES (MAX_NODES),
        .DOF_KINDS (DOF_KINDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_cmd   (ctrl_cmd),
        .cmd        (cmd),
        .node       (node),
        .dof_code   (dof_code),
        .node_count (node_count_reg),
        .dp_status  (dp_status),
        .status     (status),
        .dof_index  (dof_index)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in flight");

    a_exec_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && cmd != CMD_BUILD) |=> ##1 rsp_valid)
        else $error("edit or query response not ready two cycles after accept");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_RANGE))
        else $error("response status out of code range");

    a_error_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ST_UNKNOWN || status == ST_ABSENT || status == ST_RANGE))
        |-> (dof_index == '0))
        else $error("nonzero index on an error response");

endmodule

`default_nettype wire
